### hw/rtl/swmt_pkg.sv
// Shared types and constants for the sliding window maximum tracker.
// No dependencies; used by every RTL file of the block.
`default_nettype none

package swmt_pkg;

   localparam int WINDOW_DEFAULT = 1024;
   localparam int TIME_W = 48;
   localparam int VALUE_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [VALUE_W-1:0] GRID_STEP_RESET = 32'd65536;
   localparam logic signed [TIME_W-1:0] TIME_MIN = {1'b1, {(TIME_W-1){1'b0}}};

   // register index, taken from paddr[2]
   localparam logic REG_GRID_STEP = 1'b0;

   typedef enum logic [1:0] {
      REQ_PUSH   = 2'd0,
      REQ_QUERY  = 2'd1,
      REQ_FILL   = 2'd2,
      REQ_UNUSED = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_SHIFT  = 2'd2,
      CELL_FILL   = 2'd3
   } cell_op_type;

   typedef struct packed {
      cell_op_type               op;
      logic signed [TIME_W-1:0]  time_val;
      logic [VALUE_W-1:0]        value;
      logic signed [TIME_W-1:0]  since;
   } cell_cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_FILL_SWEEP,
      ST_PUSH_RD,
      ST_PUSH_EVICT,
      ST_CNT_SRCH,
      ST_Q_SRCH,
      ST_Q_READ,
      ST_FINISH
   } state_type;

endpackage

`default_nettype wire

### hw/rtl/swmt_cell.sv
// One deque cell: holds a (time, value) entry and a valid bit.
// Depends on swmt_pkg.
`default_nettype none

module swmt_cell (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire swmt_pkg::cell_cmd_type            cmd,
   input  wire logic                              at_front_in,
   input  wire logic                              prev_keep_in,
   input  wire logic signed [swmt_pkg::TIME_W-1:0] next_time_in,
   input  wire logic [swmt_pkg::VALUE_W-1:0]      next_value_in,
   input  wire logic                              next_valid_in,
   output logic signed [swmt_pkg::TIME_W-1:0]    time_out,
   output logic [swmt_pkg::VALUE_W-1:0]          value_out,
   output logic                                  valid_out,
   output logic                                  keep_out,
   output logic                                  lt_out
);

   logic signed [swmt_pkg::TIME_W-1:0] time_ff, time_in;
   logic [swmt_pkg::VALUE_W-1:0]       value_ff, value_in;
   logic                               valid_ff, valid_in;
   logic                               keep;

   assign keep = valid_ff && (value_ff > cmd.value);

   always_comb begin
      time_in  = time_ff;
      value_in = value_ff;
      valid_in = valid_ff;
      case (cmd.op)
         swmt_pkg::CELL_HOLD: begin
         end
         swmt_pkg::CELL_INSERT: begin
            // entries above the new value stay; first dropped slot takes it
            if (!keep) begin
               time_in  = cmd.time_val;
               value_in = cmd.value;
               valid_in = prev_keep_in;
            end
         end
         swmt_pkg::CELL_SHIFT: begin
            time_in  = next_time_in;
            value_in = next_value_in;
            valid_in = next_valid_in;
         end
         swmt_pkg::CELL_FILL: begin
            time_in  = cmd.time_val;
            value_in = cmd.value;
            valid_in = at_front_in;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      time_ff  <= time_in;
      value_ff <= value_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign time_out  = time_ff;
   assign value_out = value_ff;
   assign valid_out = valid_ff;
   assign keep_out  = keep;
   assign lt_out    = time_ff < cmd.since;

endmodule

`default_nettype wire

### hw/rtl/swmt_hist_ram.sv
// Ring of recent sample times: one write port, one registered read port.
// Depends on swmt_pkg.
`default_nettype none

module swmt_hist_ram #(
   parameter int DEPTH = swmt_pkg::WINDOW_DEFAULT,
   parameter int AW = $clog2(swmt_pkg::WINDOW_DEFAULT)
) (
   input  wire logic                              clock,
   input  wire logic                              wr_en,
   input  wire logic [AW-1:0]                     wr_addr,
   input  wire logic signed [swmt_pkg::TIME_W-1:0] wr_data,
   input  wire logic                              rd_en,
   input  wire logic [AW-1:0]                     rd_addr,
   output logic signed [swmt_pkg::TIME_W-1:0]    rd_data
);

   logic signed [swmt_pkg::TIME_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

### hw/rtl/sliding_window_max_tracker_unit.sv
// Sliding window maximum tracker, top level. Uses swmt_pkg, swmt_cell, swmt_hist_ram.
// Holds the FSM, the cell chain, the time ring and the APB register.
`default_nettype none

// The deque lives in a row of WINDOW cells, front at cell 0, values strictly
// falling towards the back. One item is worked at a time; req_stall is high
// while busy. A push goes through accept, insert with ring write, ring read,
// an evict check that repeats while the front entry is evicted, and result.
// A query runs one binary search over the cell valid bits for the fill level,
// a second over the per-cell time compare for the first entry at or after
// since_time, then the hit is read. In a fill, the ring is rewritten one slot
// a cycle by a running subtract of grid_step, clamped at the most negative
// time. Items before the first fill and request code 3 go straight to the
// result. One result beat per request; it waits in the output register while
// rsp_stall is high, and a stalled result holds the next item back. grid_step
// sits at byte 0 of the APB port.
module sliding_window_max_tracker_unit #(
   parameter int WINDOW = swmt_pkg::WINDOW_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic [1:0]                            req_type,
   input  wire logic signed [swmt_pkg::TIME_W-1:0]    req_sample_time,
   input  wire logic [swmt_pkg::VALUE_W-1:0]          req_sample_value,
   input  wire logic signed [swmt_pkg::TIME_W-1:0]    req_since_time,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic [swmt_pkg::VALUE_W-1:0]               rsp_max_value,
   output logic                                       rsp_found,
   output logic                                       rsp_not_ready,
   input  wire logic                                  csr_psel,
   input  wire logic                                  csr_penable,
   input  wire logic                                  csr_pwrite,
   input  wire logic [swmt_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  wire logic [swmt_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [swmt_pkg::CSR_DATA_W-1:0]            csr_prdata,
   output logic                                       csr_pready
);

   localparam int AW = $clog2(WINDOW);
   localparam int CW = $clog2(WINDOW + 1);
   localparam logic [AW-1:0] LAST = AW'(WINDOW - 1);
   localparam logic [CW-1:0] WIN_C = CW'(WINDOW);
   localparam int TW = swmt_pkg::TIME_W;
   localparam int VW = swmt_pkg::VALUE_W;

   // ---- configuration register ----
   logic [VW-1:0] grid_step_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == swmt_pkg::REG_GRID_STEP) ? grid_step_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_step_ff <= swmt_pkg::GRID_STEP_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite
                   && (csr_paddr[2] == swmt_pkg::REG_GRID_STEP)) begin
         grid_step_ff <= csr_pwdata;
      end
   end

   // ---- latched request ----
   swmt_pkg::state_type state_ff, state_in;
   swmt_pkg::req_kind_type kind_ff;
   logic signed [TW-1:0] t_ff, since_ff;
   logic [VW-1:0]        v_ff;
   logic                 filled_ff;

   // result staging and output register
   logic [VW-1:0] res_value_ff;
   logic          res_found_ff, res_nr_ff;
   logic          rsp_valid_ff;
   logic [VW-1:0] rsp_value_ff;
   logic          rsp_found_ff, rsp_nr_ff;

   // search and sweep
   logic [CW-1:0] lo_ff, hi_ff, count_ff, mid;
   logic [AW-1:0] hp_ff, idx_ff, hp_next;
   logic signed [TW:0] acc_ff, acc_diff;
   logic          sat_ff, under;

   // ---- cell chain ----
   swmt_pkg::cell_cmd_type cmd;
   swmt_pkg::cell_op_type  cell_op;
   logic                   tail_valid;
   logic signed [TW-1:0]   cell_time [WINDOW];
   logic [VW-1:0]          cell_value [WINDOW];
   logic [WINDOW-1:0]      cell_valid, cell_keep, cell_lt;

   assign cmd.op       = cell_op;
   assign cmd.time_val = t_ff;
   assign cmd.value    = v_ff;
   assign cmd.since    = since_ff;

   for (genvar i = 0; i < WINDOW; i++) begin : g_cell
      if (i == WINDOW - 1) begin : g_tail
         swmt_cell u_cell (
            .clock         (clock),
            .reset         (reset),
            .cmd           (cmd),
            .at_front_in   (1'b0),
            .prev_keep_in  (cell_keep[i-1]),
            .next_time_in  (t_ff),
            .next_value_in (v_ff),
            .next_valid_in (tail_valid),
            .time_out      (cell_time[i]),
            .value_out     (cell_value[i]),
            .valid_out     (cell_valid[i]),
            .keep_out      (cell_keep[i]),
            .lt_out        (cell_lt[i])
         );
      end else begin : g_body
         swmt_cell u_cell (
            .clock         (clock),
            .reset         (reset),
            .cmd           (cmd),
            .at_front_in   (i == 0),
            .prev_keep_in  ((i == 0) ? 1'b1 : cell_keep[(i == 0) ? 0 : i-1]),
            .next_time_in  (cell_time[i+1]),
            .next_value_in (cell_value[i+1]),
            .next_valid_in (cell_valid[i+1]),
            .time_out      (cell_time[i]),
            .value_out     (cell_value[i]),
            .valid_out     (cell_valid[i]),
            .keep_out      (cell_keep[i]),
            .lt_out        (cell_lt[i])
         );
      end
   end

   // ---- time ring ----
   logic                 ram_we, ram_re;
   logic [AW-1:0]        ram_waddr;
   logic signed [TW-1:0] ram_wdata, oldest;

   swmt_hist_ram #(.DEPTH(WINDOW), .AW(AW)) u_hist (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (hp_ff),
      .rd_data (oldest)
   );

   // ---- datapath helpers ----
   assign mid      = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign hp_next  = (hp_ff == LAST) ? '0 : hp_ff + 1'b1;
   assign acc_diff = acc_ff - $signed({{(TW+1-VW){1'b0}}, grid_step_ff});
   // below the most negative 48-bit time
   assign under    = acc_diff[TW] && !acc_diff[TW-1];

   logic evict;
   assign evict = cell_valid[0] && (cell_time[0] < oldest);

   logic out_free;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // ---- next state ----
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         swmt_pkg::ST_IDLE: begin
            if (req_valid) state_in = swmt_pkg::ST_DISPATCH;
         end
         swmt_pkg::ST_DISPATCH: begin
            if (kind_ff == swmt_pkg::REQ_FILL) begin
               state_in = swmt_pkg::ST_FILL_SWEEP;
            end else if (kind_ff == swmt_pkg::REQ_UNUSED || !filled_ff) begin
               state_in = swmt_pkg::ST_FINISH;
            end else if (kind_ff == swmt_pkg::REQ_PUSH) begin
               state_in = swmt_pkg::ST_PUSH_RD;
            end else begin
               state_in = swmt_pkg::ST_CNT_SRCH;
            end
         end
         swmt_pkg::ST_FILL_SWEEP: begin
            if (idx_ff == '0) state_in = swmt_pkg::ST_FINISH;
         end
         swmt_pkg::ST_PUSH_RD: state_in = swmt_pkg::ST_PUSH_EVICT;
         swmt_pkg::ST_PUSH_EVICT: begin
            if (!evict) state_in = swmt_pkg::ST_FINISH;
         end
         swmt_pkg::ST_CNT_SRCH: begin
            if (lo_ff >= hi_ff) state_in = swmt_pkg::ST_Q_SRCH;
         end
         swmt_pkg::ST_Q_SRCH: begin
            if (lo_ff >= hi_ff) begin
               state_in = (lo_ff < count_ff) ? swmt_pkg::ST_Q_READ : swmt_pkg::ST_FINISH;
            end
         end
         swmt_pkg::ST_Q_READ: state_in = swmt_pkg::ST_FINISH;
         swmt_pkg::ST_FINISH: begin
            if (out_free) state_in = swmt_pkg::ST_IDLE;
         end
         default: state_in = swmt_pkg::ST_IDLE;
      endcase
   end

   // ---- control outputs ----
   always_comb begin
      cell_op    = swmt_pkg::CELL_HOLD;
      tail_valid = 1'b0;
      ram_we     = 1'b0;
      ram_re     = 1'b0;
      ram_waddr  = hp_ff;
      ram_wdata  = t_ff;
      req_stall  = (state_ff != swmt_pkg::ST_IDLE);
      case (state_ff)
         swmt_pkg::ST_DISPATCH: begin
            if (kind_ff == swmt_pkg::REQ_FILL) begin
               cell_op = swmt_pkg::CELL_FILL;
            end else if (kind_ff == swmt_pkg::REQ_PUSH && filled_ff) begin
               // full deque (back cell kept): drop the front and append at the back; else insert
               cell_op    = cell_keep[WINDOW-1] ? swmt_pkg::CELL_SHIFT
                                                : swmt_pkg::CELL_INSERT;
               tail_valid = 1'b1;
               ram_we     = 1'b1;
            end
         end
         swmt_pkg::ST_FILL_SWEEP: begin
            ram_we    = 1'b1;
            ram_waddr = idx_ff;
            ram_wdata = sat_ff ? swmt_pkg::TIME_MIN : acc_ff[TW-1:0];
         end
         swmt_pkg::ST_PUSH_RD: ram_re = 1'b1;
         swmt_pkg::ST_PUSH_EVICT: begin
            if (evict) cell_op = swmt_pkg::CELL_SHIFT;
         end
         default: begin
         end
      endcase
   end

   // ---- registers ----
   always_ff @(posedge clock) begin
      if (state_ff == swmt_pkg::ST_IDLE && req_valid) begin
         kind_ff  <= swmt_pkg::req_kind_type'(req_type);
         t_ff     <= req_sample_time;
         v_ff     <= req_sample_value;
         since_ff <= req_since_time;
      end
      case (state_ff)
         swmt_pkg::ST_DISPATCH: begin
            res_value_ff <= (kind_ff == swmt_pkg::REQ_FILL) ? v_ff : '0;
            res_found_ff <= 1'b0;
            res_nr_ff    <= (kind_ff != swmt_pkg::REQ_FILL)
                            && (kind_ff != swmt_pkg::REQ_UNUSED) && !filled_ff;
            lo_ff        <= '0;
            hi_ff        <= WIN_C;
            idx_ff       <= LAST;
            acc_ff       <= {t_ff[TW-1], t_ff};
            sat_ff       <= 1'b0;
         end
         swmt_pkg::ST_FILL_SWEEP: begin
            idx_ff <= idx_ff - 1'b1;
            acc_ff <= acc_diff;
            if (under) sat_ff <= 1'b1;
         end
         swmt_pkg::ST_PUSH_EVICT: begin
            if (!evict) res_value_ff <= cell_valid[0] ? cell_value[0] : '0;
         end
         swmt_pkg::ST_CNT_SRCH: begin
            if (lo_ff < hi_ff) begin
               if (cell_valid[mid[AW-1:0]]) lo_ff <= mid + 1'b1;
               else hi_ff <= mid;
            end else begin
               count_ff <= lo_ff;
               hi_ff    <= lo_ff;
               lo_ff    <= '0;
            end
         end
         swmt_pkg::ST_Q_SRCH: begin
            if (lo_ff < hi_ff) begin
               if (cell_lt[mid[AW-1:0]]) lo_ff <= mid + 1'b1;
               else hi_ff <= mid;
            end
         end
         swmt_pkg::ST_Q_READ: begin
            res_value_ff <= cell_value[lo_ff[AW-1:0]];
            res_found_ff <= 1'b1;
         end
         default: begin
         end
      endcase
      if (state_ff == swmt_pkg::ST_FINISH && out_free) begin
         rsp_value_ff <= res_value_ff;
         rsp_found_ff <= res_found_ff;
         rsp_nr_ff    <= res_nr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= swmt_pkg::ST_IDLE;
         filled_ff    <= 1'b0;
         hp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == swmt_pkg::ST_DISPATCH) begin
            if (kind_ff == swmt_pkg::REQ_FILL) begin
               filled_ff <= 1'b1;
               hp_ff     <= '0;
            end else if (kind_ff == swmt_pkg::REQ_PUSH && filled_ff) begin
               hp_ff <= hp_next;
            end
         end
         if (state_ff == swmt_pkg::ST_FINISH && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_max_value = rsp_value_ff;
   assign rsp_found     = rsp_found_ff;
   assign rsp_not_ready = rsp_nr_ff;

`ifndef NO_ASSERTIONS
   // once filled, the block never forgets it
   a_filled_sticky: assert property (@(posedge clock) disable iff (reset)
      !$fell(filled_ff)) else $error("filled flag dropped");

   // an empty front cell means the whole chain is empty
   a_valid_prefix: assert property (@(posedge clock) disable iff (reset)
      !cell_valid[0] |-> (cell_valid == '0)) else $error("deque hole at front");

   // a result is never both a hit and a not-ready
   a_rsp_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_found && rsp_not_ready)) else $error("conflicting flags");

   // the time ring is only written while the sweep or a push runs
   a_ram_we: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == swmt_pkg::ST_FILL_SWEEP || state_ff == swmt_pkg::ST_DISPATCH))
      else $error("stray ring write");
`endif

endmodule

`default_nettype wire
